// File: sv/ptst_pkg.sv
package ptst_pkg;

  localparam int unsigned NW = 63;
  localparam int unsigned CW = 6;
  localparam int unsigned WCOUNT = 7;
  localparam int unsigned WIDX_W = 3;

  typedef logic [NW-1:0] word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_WLOAD,
    ST_WRED,
    ST_PSQ,
    ST_PMUL,
    ST_CHECK,
    ST_SQ,
    ST_DONE
  } state_t;

  function automatic word_t witness(input logic [WIDX_W-1:0] idx);
    word_t w;
    case (idx)
      3'd0: w = word_t'(2);
      3'd1: w = word_t'(325);
      3'd2: w = word_t'(9375);
      3'd3: w = word_t'(28178);
      3'd4: w = word_t'(450775);
      3'd5: w = word_t'(9780504);
      3'd6: w = word_t'(1795265022);
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// File: sv/ptst_mulmod.sv
module ptst_mulmod (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ptst_pkg::word_t   x,
  input  ptst_pkg::word_t   y,
  input  ptst_pkg::word_t   m,
  output logic              done,
  output ptst_pkg::word_t   prod
);

  // Serial shift-and-add: one multiplier bit per cycle, MSB first, with the
  // accumulator kept below m after every double and every add. The x operand
  // must already be below m; y may be any 63-bit value.
  logic            busy_r, busy_nxt;
  logic [ptst_pkg::CW-1:0] cnt_r, cnt_nxt;
  ptst_pkg::word_t acc_r, acc_nxt;
  ptst_pkg::word_t ysh_r, ysh_nxt;
  ptst_pkg::word_t x_r, m_r;
  logic            done_r, done_nxt;

  logic [ptst_pkg::NW:0] dbl, dsub, sum, ssub;
  ptst_pkg::word_t       acc2;

  always_comb begin
    dbl  = {acc_r, 1'b0};
    dsub = dbl - {1'b0, m_r};
    acc2 = dsub[ptst_pkg::NW] ? acc_r << 1 : dsub[ptst_pkg::NW-1:0];
    sum  = {1'b0, acc2} + {1'b0, x_r};
    ssub = sum - {1'b0, m_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    ysh_nxt  = ysh_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ptst_pkg::CW'(ptst_pkg::NW - 1);
      acc_nxt  = '0;
      ysh_nxt  = y;
    end else if (busy_r) begin
      if (ysh_r[ptst_pkg::NW-1]) begin
        acc_nxt = ssub[ptst_pkg::NW] ? sum[ptst_pkg::NW-1:0] : ssub[ptst_pkg::NW-1:0];
      end else begin
        acc_nxt = acc2;
      end
      ysh_nxt = ysh_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    ysh_r <= ysh_nxt;
    if (start) begin
      x_r <= x;
      m_r <= m;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: sv/primality_test_64bit.sv
// Deterministic Miller-Rabin test of a 63-bit candidate with the seven fixed
// witnesses 2, 325, 9375, 28178, 450775, 9780504 and 1795265022, which give the
// exact answer for every value below 2^64. One item is worked on at a time;
// in_ready is high only while the block is idle. Every modular product goes
// through one shared bit-serial multiplier that takes a load step and then 63
// bit steps for each product, so the cost of an item grows with the number of
// products: per witness one reduction, 63 squarings of the exponent scan and
// at most 62 multiplies and final squarings together, so up to 7 * 126
// products in all for a large prime that passes every witness, and
// far fewer for values that are even, below three or are rejected by an early
// witness. Splitting n-1 into its odd part and power of two shifts one bit a
// cycle. The witness is reduced modulo n by multiplying one by it, which
// shifts the witness bits in one at a time, so a witness that the candidate
// divides is caught on the reduced value being zero. The exponent is scanned
// from its most significant bit: square, then multiply. The result waits in
// an output register until out_ready; the next item may already be taken and
// worked on while it waits, and its verdict is only moved out once the
// previous one has left.
module primality_test_64bit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ptst_pkg::NW-1:0]  in_candidate,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_is_prime
);

  ptst_pkg::state_t state_r, state_nxt;
  ptst_pkg::word_t  n_r, n_nxt;
  ptst_pkg::word_t  d_r, d_nxt;          // odd part of n-1
  logic [ptst_pkg::CW-1:0] s_r, s_nxt;   // power of two in n-1
  logic [ptst_pkg::CW-1:0] k_r, k_nxt;   // squarings done
  logic [ptst_pkg::CW-1:0] eb_r, eb_nxt; // exponent bit index
  logic [ptst_pkg::WIDX_W-1:0] wi_r, wi_nxt;
  ptst_pkg::word_t  a_r, a_nxt;          // reduced witness
  ptst_pkg::word_t  r_r, r_nxt;          // running value
  logic             res_r, res_nxt;      // verdict of the item in work
  logic             ov_r, ov_nxt;
  logic             out_r, out_nxt;      // verdict on the output

  logic             mm_start;
  ptst_pkg::word_t  mm_x, mm_y;
  logic             mm_done;
  ptst_pkg::word_t  mm_prod;
  ptst_pkg::word_t  nm1;

  ptst_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .x     (mm_x),
    .y     (mm_y),
    .m     (n_r),
    .done  (mm_done),
    .prod  (mm_prod)
  );

  assign nm1 = n_r - 1'b1;

  always_comb begin
    state_nxt = state_r;
    n_nxt  = n_r;
    d_nxt  = d_r;
    s_nxt  = s_r;
    k_nxt  = k_r;
    eb_nxt = eb_r;
    wi_nxt = wi_r;
    a_nxt  = a_r;
    r_nxt  = r_r;
    res_nxt = res_r;
    ov_nxt = ov_r;
    out_nxt = out_r;
    mm_start = 1'b0;
    mm_x = r_r;
    mm_y = r_r;
    in_ready = (state_r == ptst_pkg::ST_IDLE);
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      ptst_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          n_nxt = in_candidate;
          if (in_candidate <= ptst_pkg::word_t'(1)) begin
            res_nxt = 1'b0;
            state_nxt = ptst_pkg::ST_DONE;
          end else if (in_candidate == ptst_pkg::word_t'(2)) begin
            res_nxt = 1'b1;
            state_nxt = ptst_pkg::ST_DONE;
          end else if (!in_candidate[0]) begin
            res_nxt = 1'b0;
            state_nxt = ptst_pkg::ST_DONE;
          end else begin
            d_nxt = in_candidate >> 1;
            s_nxt = ptst_pkg::CW'(1);
            state_nxt = ptst_pkg::ST_SPLIT;
          end
        end
      end
      ptst_pkg::ST_SPLIT: begin
        if (d_r[0]) begin
          wi_nxt = '0;
          state_nxt = ptst_pkg::ST_WLOAD;
        end else begin
          d_nxt = d_r >> 1;
          s_nxt = s_r + 1'b1;
        end
      end
      ptst_pkg::ST_WLOAD: begin
        // One times the witness, with the witness as the shifted operand,
        // leaves the witness modulo n even when it exceeds n many times.
        mm_x = ptst_pkg::word_t'(1);
        mm_y = ptst_pkg::witness(wi_r);
        mm_start = 1'b1;
        state_nxt = ptst_pkg::ST_WRED;
      end
      ptst_pkg::ST_WRED: begin
        if (mm_done) begin
          if (mm_prod == '0) begin
            res_nxt = 1'b1;
            state_nxt = ptst_pkg::ST_DONE;
          end else begin
            a_nxt = mm_prod;
            r_nxt = ptst_pkg::word_t'(1);
            eb_nxt = ptst_pkg::CW'(ptst_pkg::NW - 1);
            mm_x = ptst_pkg::word_t'(1);
            mm_y = ptst_pkg::word_t'(1);
            mm_start = 1'b1;
            state_nxt = ptst_pkg::ST_PSQ;
          end
        end
      end
      ptst_pkg::ST_PSQ: begin
        if (mm_done) begin
          r_nxt = mm_prod;
          if (d_r[eb_r]) begin
            mm_x = mm_prod;
            mm_y = a_r;
            mm_start = 1'b1;
            state_nxt = ptst_pkg::ST_PMUL;
          end else if (eb_r == '0) begin
            state_nxt = ptst_pkg::ST_CHECK;
          end else begin
            eb_nxt = eb_r - 1'b1;
            mm_x = mm_prod;
            mm_y = mm_prod;
            mm_start = 1'b1;
          end
        end
      end
      ptst_pkg::ST_PMUL: begin
        if (mm_done) begin
          r_nxt = mm_prod;
          if (eb_r == '0) begin
            k_nxt = '0;
            state_nxt = ptst_pkg::ST_CHECK;
          end else begin
            eb_nxt = eb_r - 1'b1;
            mm_x = mm_prod;
            mm_y = mm_prod;
            mm_start = 1'b1;
            state_nxt = ptst_pkg::ST_PSQ;
          end
        end
      end
      ptst_pkg::ST_CHECK: begin
        // r is w^(d*2^k); pass on 1 at k=0 or n-1 at any k below s.
        if ((k_r == '0 && r_r == ptst_pkg::word_t'(1)) || r_r == nm1) begin
          if (wi_r == ptst_pkg::WIDX_W'(ptst_pkg::WCOUNT - 1)) begin
            res_nxt = 1'b1;
            state_nxt = ptst_pkg::ST_DONE;
          end else begin
            wi_nxt = wi_r + 1'b1;
            state_nxt = ptst_pkg::ST_WLOAD;
          end
        end else if (k_r + 1'b1 >= s_r) begin
          res_nxt = 1'b0;
          state_nxt = ptst_pkg::ST_DONE;
        end else begin
          k_nxt = k_r + 1'b1;
          mm_start = 1'b1;
          state_nxt = ptst_pkg::ST_SQ;
        end
      end
      ptst_pkg::ST_SQ: begin
        if (mm_done) begin
          r_nxt = mm_prod;
          state_nxt = ptst_pkg::ST_CHECK;
        end
      end
      ptst_pkg::ST_DONE: begin
        // The verdict moves out once the output register is free or is
        // being emptied in this cycle.
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          out_nxt = res_r;
          state_nxt = ptst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ptst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptst_pkg::ST_IDLE;
      ov_r    <= 1'b0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      k_r     <= (state_r == ptst_pkg::ST_WRED) ? '0 : k_nxt;
    end
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    s_r   <= s_nxt;
    eb_r  <= eb_nxt;
    wi_r  <= wi_nxt;
    a_r   <= a_nxt;
    r_r   <= r_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid    = ov_r;
  assign out_is_prime = out_r;

  // A waiting result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_is_prime)))
    else $error("result changed or dropped while waiting");

  // The multiplier is only started on the way into a product state.
  a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
    mm_start |-> (state_nxt == ptst_pkg::ST_WRED || state_nxt == ptst_pkg::ST_PSQ
                  || state_nxt == ptst_pkg::ST_PMUL || state_nxt == ptst_pkg::ST_SQ))
    else $error("multiplier started outside a product state");

  // A result appears only out of the finishing state.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ptst_pkg::ST_DONE)
    else $error("result raised without finishing");

endmodule
